>>> src/lscd_pkg.sv
// shared constants, types and codes for the latin square cell domain block
// no dependencies; used by every module under src
package lscd_pkg;

	localparam int MAX_ORDER = 32;
	localparam int IDX_W     = $clog2(MAX_ORDER);
	localparam int NUM_W     = IDX_W + 1;
	localparam int ADDR_W    = 2 * IDX_W;
	localparam int DEPTH     = MAX_ORDER * MAX_ORDER;
	localparam int CELL_W    = 6;

	localparam logic [CELL_W-1:0] CELL_EMPTY  = '1;
	localparam logic [NUM_W-1:0]  ORDER_RESET = NUM_W'(MAX_ORDER);
	localparam logic [NUM_W-1:0]  ORDER_MAX   = NUM_W'(MAX_ORDER);

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam int          PADDR_W    = 3;
	localparam logic [PADDR_W-1:0] REG_ORDER = 3'd0;

	typedef struct packed {
		logic              rd;
		logic              wr;
		logic [ADDR_W-1:0] addr;
		logic [CELL_W-1:0] wdata;
	} mem_req_t;

endpackage

>>> src/latin_square_cell_domain_core.sv
// top level of the latin square cell domain block: order register on the
// apb port, cell store and query sequencer; depends on lscd_pkg, lscd_store, lscd_ctrl
//
// channel  direction  handshake           payload
// in       input      in_valid/in_stall   opcode, row, col, cell_value
// out      output     out_valid/out_stall free_value, domain_size, none_free, last
// cfg      apb        psel/penable/pready order at byte address 0
//
// a write goes to the store when accepted; a query runs one accept, 2n store
// reads on the single memory port, a wait state to mark the last read, then a
// scan of one value per cycle while sending results, unless out_stall holds it.
// after reset the store is cleared one cell a cycle over all 1024 cells, with
// in_stall high; order writes are taken throughout.
// out_stall holds a valid output register and stops the result scan at the next free value.
module latin_square_cell_domain_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lscd_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          opcode,
	input  logic [4:0]                    row,
	input  logic [4:0]                    col,
	input  logic signed [5:0]             cell_value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [4:0]                    free_value,
	output logic [5:0]                    domain_size,
	output logic                          none_free,
	output logic                          last
);

	logic [lscd_pkg::NUM_W-1:0]  order_q;
	lscd_pkg::mem_req_t          req;
	logic [lscd_pkg::CELL_W-1:0] rdata;
	logic                        clr_busy;
	logic                        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= lscd_pkg::ORDER_RESET;
		end else if (cfg_wr && paddr == lscd_pkg::REG_ORDER) begin
			order_q <= pwdata[lscd_pkg::NUM_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == lscd_pkg::REG_ORDER) begin
			prdata = 32'(order_q);
		end
	end

	lscd_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rdata    (rdata),
		.clr_busy (clr_busy)
	);

	lscd_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.order       (order_q),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.row         (row),
		.col         (col),
		.cell_value  (cell_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.free_value  (free_value),
		.domain_size (domain_size),
		.none_free   (none_free),
		.last        (last),
		.req         (req),
		.rdata       (rdata),
		.clr_busy    (clr_busy)
	);

endmodule

>>> src/lscd_store.sv
// cell store: single-port synchronous memory; read data is registered and valid in the cycle after the read
// runs a clearing pass after reset; depends on lscd_pkg
module lscd_store (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lscd_pkg::mem_req_t          req,
	output logic [lscd_pkg::CELL_W-1:0] rdata,
	output logic                        clr_busy
);

	logic [lscd_pkg::CELL_W-1:0] mem [lscd_pkg::DEPTH];
	logic [lscd_pkg::ADDR_W-1:0] clr_q;
	logic                        busy_q;
	logic [lscd_pkg::CELL_W-1:0] rdata_q;

	logic                        wr_en;
	logic [lscd_pkg::ADDR_W-1:0] wr_addr;
	logic [lscd_pkg::CELL_W-1:0] wr_data;

	assign wr_en   = busy_q | req.wr;
	assign wr_addr = busy_q ? clr_q : req.addr;
	assign wr_data = busy_q ? lscd_pkg::CELL_EMPTY : req.wdata;

	// one entry per cycle until the whole store reads empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == '1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (req.rd) begin
			rdata_q <= mem[req.addr];
		end
	end

	assign rdata    = rdata_q;
	assign clr_busy = busy_q;

endmodule

>>> src/lscd_ctrl.sv
// query sequencer: scans the row and column through the store, builds the
// used mask and count, then sends the free values; depends on lscd_pkg
module lscd_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [lscd_pkg::NUM_W-1:0]  order,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        opcode,
	input  logic [4:0]                  row,
	input  logic [4:0]                  col,
	input  logic signed [5:0]           cell_value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [4:0]                  free_value,
	output logic [5:0]                  domain_size,
	output logic                        none_free,
	output logic                        last,
	output lscd_pkg::mem_req_t          req,
	input  logic [lscd_pkg::CELL_W-1:0] rdata,
	input  logic                        clr_busy
);

	typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_WAIT, ST_EMIT} state_t;

	state_t                        state_q;
	logic [lscd_pkg::IDX_W-1:0]    row_q;
	logic [lscd_pkg::IDX_W-1:0]    col_q;
	logic [lscd_pkg::NUM_W-1:0]    n_q;
	logic [lscd_pkg::NUM_W-1:0]    step_q;
	logic                          rd_s1;
	logic [lscd_pkg::MAX_ORDER-1:0] mask_q;
	logic [lscd_pkg::NUM_W-1:0]    cnt_q;
	logic [lscd_pkg::IDX_W-1:0]    j_q;
	logic [lscd_pkg::NUM_W-1:0]    emitted_q;
	logic                          out_valid_q;
	logic [4:0]                    free_value_q;
	logic [5:0]                    domain_size_q;
	logic                          none_free_q;
	logic                          last_q;

	logic                          in_accept;
	logic [lscd_pkg::NUM_W-1:0]    n_eff;
	logic [lscd_pkg::NUM_W-1:0]    last_step;
	logic [lscd_pkg::IDX_W-1:0]    sidx;
	logic [lscd_pkg::IDX_W-1:0]    vidx;
	logic                          hit;
	logic                          fresh;
	logic [lscd_pkg::NUM_W-1:0]    size;
	logic                          can_load;
	logic                          is_last;
	logic                          emit_load;

	assign in_stall  = (state_q != ST_IDLE) | clr_busy;
	assign in_accept = in_valid & ~in_stall;

	always_comb begin
		if (order == '0) begin
			n_eff = lscd_pkg::NUM_W'(1);
		end else if (order > lscd_pkg::ORDER_MAX) begin
			n_eff = lscd_pkg::ORDER_MAX;
		end else begin
			n_eff = order;
		end
	end

	// 2n reads: even steps walk the row, odd steps walk the column
	assign last_step = lscd_pkg::NUM_W'({n_q, 1'b0} - 1'b1);
	assign sidx      = step_q[lscd_pkg::IDX_W:1];

	always_comb begin
		req       = '0;
		req.wdata = cell_value;
		if (state_q == ST_READ) begin
			req.rd   = 1'b1;
			req.addr = step_q[0] ? {sidx, col_q} : {row_q, sidx};
		end else begin
			req.wr   = in_accept & (opcode == lscd_pkg::OP_WRITE);
			req.addr = {row[lscd_pkg::IDX_W-1:0], col[lscd_pkg::IDX_W-1:0]};
		end
	end

	// negative cells and values outside the order leave the mask alone
	assign vidx  = rdata[lscd_pkg::IDX_W-1:0];
	assign hit   = rd_s1 & ~rdata[lscd_pkg::CELL_W-1] & ({1'b0, vidx} < n_q);
	assign fresh = hit & ~mask_q[vidx];

	assign size     = n_q - cnt_q;
	assign can_load = ~out_valid_q | ~out_stall;
	assign is_last  = (emitted_q + 1'b1) == size;

	// output register loads on a free value or on the empty-domain result
	assign emit_load = (state_q == ST_EMIT) & can_load & ((size == '0) | ~mask_q[j_q]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			row_q         <= '0;
			col_q         <= '0;
			n_q           <= lscd_pkg::ORDER_RESET;
			step_q        <= '0;
			rd_s1         <= 1'b0;
			mask_q        <= '0;
			cnt_q         <= '0;
			j_q           <= '0;
			emitted_q     <= '0;
			out_valid_q   <= 1'b0;
			free_value_q  <= '0;
			domain_size_q <= '0;
			none_free_q   <= 1'b0;
			last_q        <= 1'b0;
		end else begin
			rd_s1       <= (state_q == ST_READ);
			out_valid_q <= emit_load | (out_valid_q & out_stall);
			if (fresh) begin
				mask_q[vidx] <= 1'b1;
				cnt_q        <= cnt_q + 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept && opcode == lscd_pkg::OP_QUERY) begin
						row_q     <= row[lscd_pkg::IDX_W-1:0];
						col_q     <= col[lscd_pkg::IDX_W-1:0];
						n_q       <= n_eff;
						step_q    <= '0;
						mask_q    <= '0;
						cnt_q     <= '0;
						j_q       <= '0;
						emitted_q <= '0;
						state_q   <= ST_READ;
					end
				end
				ST_READ: begin
					step_q <= step_q + 1'b1;
					if (step_q == last_step) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					// last read data is marked in this cycle
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (size == '0) begin
						if (can_load) begin
							free_value_q  <= '0;
							domain_size_q <= '0;
							none_free_q   <= 1'b1;
							last_q        <= 1'b1;
							state_q       <= ST_IDLE;
						end
					end else if (mask_q[j_q]) begin
						j_q <= j_q + 1'b1;
					end else if (can_load) begin
						free_value_q  <= 5'(j_q);
						domain_size_q <= 6'(size);
						none_free_q   <= 1'b0;
						last_q        <= is_last;
						emitted_q     <= emitted_q + 1'b1;
						j_q           <= j_q + 1'b1;
						if (is_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign free_value  = free_value_q;
	assign domain_size = domain_size_q;
	assign none_free   = none_free_q;
	assign last        = last_q;

`ifndef ASSERT_OFF
	a_none_free_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && none_free_q |-> last_q)
		else $error("none_free result without last");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> cnt_q <= n_q)
		else $error("used count above order");

	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT && size != '0 |-> emitted_q < size)
		else $error("more results than domain size");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> step_q <= last_step)
		else $error("read step beyond row and column");

	a_no_read_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !req.wr && state_q == ST_IDLE)
		else $error("store access during clearing pass");
`endif

endmodule

>>> verif/latin_square_cell_domain_core_tb.sv
`timescale 1ns / 1ps
// testbench for latin_square_cell_domain_core: drives cell writes and domain queries,
// predicts every free value from its own copy of the cell store and checks each result
// depends on lscd_pkg and the rtl under src
module latin_square_cell_domain_core_tb;

	localparam int DRAIN_CYCLES = 3 * lscd_pkg::MAX_ORDER + 4;

	typedef struct packed {
		logic [4:0] free_value;
		logic [5:0] domain_size;
		logic       none_free;
		logic       last;
	} domain_result_t;

	class domain_scoreboard;
		logic [lscd_pkg::CELL_W-1:0] cells [lscd_pkg::DEPTH];
		logic [5:0]        order_reg;
		domain_result_t    expected_q [$];
		int errors, n_items, n_queries, n_results, n_empty;

		function new();
			foreach (cells[i]) cells[i] = lscd_pkg::CELL_EMPTY;
			order_reg = lscd_pkg::ORDER_RESET;
			errors = 0;
			n_items = 0;
			n_queries = 0;
			n_results = 0;
			n_empty = 0;
		endfunction

		function int eff_order();
			if (order_reg == 0) return 1;
			if (order_reg > lscd_pkg::MAX_ORDER) return lscd_pkg::MAX_ORDER;
			return int'(order_reg);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		task report(string msg);
			errors++;
			// keep the log short when the block is badly off
			if (errors <= 40) $display("[%0t] mismatch: %s", $realtime, msg);
		endtask

		// one accepted transfer on the input channel
		task note_input(logic op, logic [4:0] r, logic [4:0] c, logic [5:0] v);
			logic [lscd_pkg::MAX_ORDER-1:0] used;
			logic [lscd_pkg::CELL_W-1:0]    val;
			domain_result_t       res;
			int n, size, k;
			n_items++;
			if (op == lscd_pkg::OP_WRITE) begin
				cells[{r, c}] = v;
				return;
			end
			n_queries++;
			n = eff_order();
			used = '0;
			for (int i = 0; i < n; i++) begin
				val = cells[{r, 5'(i)}];
				if (!val[lscd_pkg::CELL_W-1] && val < n) used[val[4:0]] = 1'b1;
				val = cells[{5'(i), c}];
				if (!val[lscd_pkg::CELL_W-1] && val < n) used[val[4:0]] = 1'b1;
			end
			size = n - $countones(used);
			if (size == 0) begin
				res.free_value = '0;
				res.domain_size = '0;
				res.none_free = 1'b1;
				res.last = 1'b1;
				expected_q.push_back(res);
				return;
			end
			k = 0;
			for (int i = 0; i < n; i++) begin
				if (!used[i]) begin
					k++;
					res.free_value = 5'(i);
					res.domain_size = 6'(size);
					res.none_free = 1'b0;
					res.last = (k == size);
					expected_q.push_back(res);
				end
			end
		endtask

		task check_result(logic [4:0] fv, logic [5:0] ds, logic nf, logic lst);
			domain_result_t want;
			n_results++;
			if (nf) n_empty++;
			if (expected_q.size() == 0) begin
				report($sformatf("result value %0d size %0d with nothing expected", fv, ds));
				return;
			end
			want = expected_q.pop_front();
			if (fv !== want.free_value)
				report($sformatf("free_value %0d, expected %0d", fv, want.free_value));
			if (ds !== want.domain_size)
				report($sformatf("domain_size %0d, expected %0d", ds, want.domain_size));
			if (nf !== want.none_free)
				report($sformatf("none_free %0b, expected %0b", nf, want.none_free));
			if (lst !== want.last)
				report($sformatf("last %0b, expected %0b", lst, want.last));
		endtask

		task leftover_check();
			domain_result_t want;
			while (expected_q.size() != 0) begin
				want = expected_q.pop_front();
				report($sformatf("expected value %0d size %0d never came out",
					want.free_value, want.domain_size));
			end
		endtask
	endclass

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [lscd_pkg::PADDR_W-1:0] paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;
	logic                in_valid;
	logic                in_stall;
	logic                opcode;
	logic [4:0]          row;
	logic [4:0]          col;
	logic signed [5:0]   cell_value;
	logic                out_valid;
	logic                out_stall;
	logic [4:0]          free_value;
	logic [5:0]          domain_size;
	logic                none_free;
	logic                last;

	domain_scoreboard sb;
	logic gaps_on;
	int   n_settings;

	latin_square_cell_domain_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.row         (row),
		.col         (col),
		.cell_value  (cell_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.free_value  (free_value),
		.domain_size (domain_size),
		.none_free   (none_free),
		.last        (last)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (!gaps_on || roll < 55) return 0;
		if (roll < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// order register write: setup cycle, then access cycle until pready
	task automatic cfg_write(logic [5:0] ord);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= lscd_pkg::REG_ORDER;
		pwdata <= {26'($urandom), ord};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		sb.order_reg = ord;
		n_settings++;
	endtask

	task automatic send_item(logic op, logic [4:0] r, logic [4:0] c, logic [5:0] v);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		row <= r;
		col <= c;
		cell_value <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_input(op, r, c, v);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// mostly legal fills and queries inside the order, some erases and raw noise
	task automatic random_item();
		logic       op;
		logic [4:0] r, c;
		logic [5:0] v;
		int n, pick;
		n = sb.eff_order();
		pick = $urandom_range(0, 99);
		op = lscd_pkg::OP_WRITE;
		r = 5'($urandom_range(0, n - 1));
		c = 5'($urandom_range(0, n - 1));
		v = 6'($urandom_range(0, n - 1));
		if (pick < 10) begin
			v = lscd_pkg::CELL_EMPTY;
		end else if (pick >= 50 && pick < 88) begin
			op = lscd_pkg::OP_QUERY;
		end else if (pick >= 88) begin
			op = 1'($urandom);
			r = 5'($urandom);
			c = 5'($urandom);
			v = 6'($urandom);
		end
		send_item(op, r, c, v);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(free_value, domain_size, none_free, last);
	end

	initial begin
		int run_len, hold_len;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 6);
			hold_len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
				: $urandom_range(1, 3);
			repeat (run_len) @(posedge clk);
			out_stall <= 1'b1;
			repeat (hold_len) @(posedge clk);
			out_stall <= 1'b0;
		end
	end

	initial begin
		#10_000_000;
		$display("latin_square_cell_domain_core_tb failed");
		$finish;
	end

	initial begin
		int phase_order [6];
		int phase_len [6];
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		opcode = lscd_pkg::OP_WRITE;
		row = '0;
		col = '0;
		cell_value = '0;
		gaps_on = 1'b1;
		n_settings = 0;
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// order write lands during the store clearing pass
		cfg_write(lscd_pkg::ORDER_MAX);

		// full order: empty store, extreme corners, odd negatives
		send_item(lscd_pkg::OP_QUERY, 5'd0, 5'd0, 6'd0);
		send_item(lscd_pkg::OP_WRITE, 5'd0, 5'd0, 6'd31);
		send_item(lscd_pkg::OP_WRITE, 5'd0, 5'd31, 6'd0);
		send_item(lscd_pkg::OP_WRITE, 5'd31, 5'd0, 6'(-32));
		send_item(lscd_pkg::OP_WRITE, 5'd5, 5'd0, 6'(-2));
		send_item(lscd_pkg::OP_WRITE, 5'd0, 5'd7, lscd_pkg::CELL_EMPTY);
		send_item(lscd_pkg::OP_WRITE, 5'd31, 5'd31, 6'd31);
		send_item(lscd_pkg::OP_WRITE, 5'd17, 5'd0, 6'd16);
		send_item(lscd_pkg::OP_WRITE, 5'd0, 5'd3, 6'd3);
		send_item(lscd_pkg::OP_QUERY, 5'd0, 5'd0, 6'd0);
		send_item(lscd_pkg::OP_QUERY, 5'd31, 5'd31, 6'd31);
		send_item(lscd_pkg::OP_QUERY, 5'd0, 5'd5, 6'(-1));
		send_item(lscd_pkg::OP_QUERY, 5'd5, 5'd31, 6'd0);
		send_item(lscd_pkg::OP_WRITE, 5'd0, 5'd0, lscd_pkg::CELL_EMPTY);
		send_item(lscd_pkg::OP_QUERY, 5'd0, 5'd0, 6'd0);
		wait_drained();

		// order 2: full row gives an empty domain, value above order, address outside
		cfg_write(6'd2);
		send_item(lscd_pkg::OP_WRITE, 5'd0, 5'd0, 6'd0);
		send_item(lscd_pkg::OP_WRITE, 5'd0, 5'd1, 6'd1);
		send_item(lscd_pkg::OP_QUERY, 5'd0, 5'd0, 6'd0);
		send_item(lscd_pkg::OP_WRITE, 5'd1, 5'd0, 6'd5);
		send_item(lscd_pkg::OP_QUERY, 5'd1, 5'd1, 6'd0);
		send_item(lscd_pkg::OP_QUERY, 5'd20, 5'd20, 6'd0);
		wait_drained();

		// order zero acts as order one
		cfg_write(6'd0);
		send_item(lscd_pkg::OP_QUERY, 5'd0, 5'd0, 6'd0);
		send_item(lscd_pkg::OP_WRITE, 5'd0, 5'd0, 6'd1);
		send_item(lscd_pkg::OP_QUERY, 5'd0, 5'd0, 6'd0);
		wait_drained();

		// above the maximum saturates
		cfg_write(6'd63);
		send_item(lscd_pkg::OP_QUERY, 5'd0, 5'd0, 6'd0);
		wait_drained();

		phase_order = '{3, 5, 1, 32, 0, 0};
		phase_order[4] = $urandom_range(2, 9);
		phase_order[5] = $urandom_range(0, 63);
		phase_len = '{15, 15, 8, 15, 12, 12};
		for (int p = 0; p < 6; p++) begin
			cfg_write(6'(phase_order[p]));
			gaps_on = (p == 3) ? 1'b0 : 1'($urandom_range(0, 3) != 0);
			for (int i = 0; i < phase_len[p]; i++) begin
				// hold the sender until every result so far is out
				if (i == phase_len[p] / 2) wait_drained();
				random_item();
			end
			wait_drained();
		end

		sb.leftover_check();
		$display("covered %0d input transfers (%0d queries), %0d results, %0d empty domains",
			sb.n_items, sb.n_queries, sb.n_results, sb.n_empty);
		$display("order register set %0d times, zero and saturation included", n_settings);
		if (sb.errors == 0)
			$display("latin_square_cell_domain_core_tb passed");
		else
			$display("latin_square_cell_domain_core_tb failed");
		$finish;
	end

endmodule
